// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcc same-cycle check failed");

// Next-cycle implication, held off during reset.
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcc next-cycle check failed");

`endif

// File: rtl/tcc_pkg.sv
// Shared widths, payload types and codes of the triangle circumcircle unit.
// Depends on nothing; the design and checker files use it by scoped names.
package tcc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;

    // Derived arithmetic widths
    localparam int DIFF_W = COORD_WIDTH + 1;          // edge vector component
    localparam int PROD_W = 2 * DIFF_W;               // product of two components
    localparam int NORM_W = 2 * COORD_WIDTH + 1;      // squared edge length
    localparam int DV_W   = 2 * COORD_WIDTH + 2;      // |d|
    localparam int DS_W   = DV_W + 1;                 // signed d
    localparam int NUM_W  = 3 * COORD_WIDTH + 2;      // |numerator|
    localparam int QUO_W  = NUM_W + FRAC_BITS;        // |u| before clamping
    localparam int RES_W  = 32;                       // result field width
    localparam int SQS_W  = 2 * RES_W;                // radicand width
    localparam int REM_W  = RES_W + 2;                // root remainder width

    // Stream widths
    localparam int IN_FIELDS_W = 6 * COORD_WIDTH;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 3 * RES_W;
    localparam int OUT_USER_W  = 2;

    // Bit positions inside the output tuser
    localparam int USER_DEGEN = 0;
    localparam int USER_OVF   = 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic                          degen;
    } div_side_t;

    typedef struct packed {
        logic [NUM_W-1:0] nx_mag;
        logic [NUM_W-1:0] ny_mag;
        logic             qx_neg;
        logic             qy_neg;
        logic [DV_W-1:0]  dv;
        div_side_t        side;
    } front_out_t;

    typedef struct packed {
        logic [QUO_W-1:0] qx_mag;
        logic [QUO_W-1:0] qy_mag;
        logic             qx_neg;
        logic             qy_neg;
        div_side_t        side;
    } div_out_t;

    typedef struct packed {
        logic [RES_W-1:0] center_x;
        logic [RES_W-1:0] center_y;
        logic [RES_W-1:0] radius;
        logic             degenerate;
        logic             overflow;
    } result_t;

endpackage

// File: rtl/triangle_circumcircle_2d_unit.sv
// Channel | Dir | tdata                                     | tuser
// s_axis  | in  | p0_x p0_y p1_x p1_y p2_x p2_y (16 b each)  | -
// m_axis  | out | center_x center_y radius (32 b each)      | degenerate, overflow
//
// One triangle per cycle when the output is taken; pipeline stages:
// 6 front stages, 58 divider stages (one quotient bit each), 35 back-end
// stages (32 of them root bits), then the output register.
// Reset clears only the valid bits; no clearing pass.
// Output register plus one skid beat: on an output stall the next offered beat
// parks in the skid, then the pipe holds until the skid drains.
// Top level of the triangle circumcircle unit; depends on tcc_pkg, tcc_front,
// tcc_div and tcc_rad.
module triangle_circumcircle_2d_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tcc_pkg::IN_DATA_W-1:0]      s_tdata,   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tcc_pkg::OUT_DATA_W-1:0]     m_tdata,   // center_x, center_y, radius
    output logic [tcc_pkg::OUT_USER_W-1:0]     m_tuser    // degenerate, overflow
);

    logic                 en;
    logic                 front_valid;
    tcc_pkg::front_out_t  front_data;
    logic                 div_valid;
    tcc_pkg::div_out_t    div_data;
    logic                 rad_valid;
    tcc_pkg::result_t     rad_data;
    logic                 offer;
    logic                 out_vld_reg, skid_vld_reg;
    tcc_pkg::result_t     out_reg, skid_reg;

    // The whole pipe advances unless the skid beat is occupied
    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign offer    = rad_valid && en;

    tcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_coords (s_tdata[tcc_pkg::IN_FIELDS_W-1:0]),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    tcc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    tcc_rad u_rad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (rad_valid),
        .out_data  (rad_data)
    );

    // Output register with skid: drain skid first, park a beat when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_tready)
        begin
            out_vld_reg  <= skid_vld_reg || offer;
            skid_vld_reg <= 1'b0;
        end
        else if (offer)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_tready)
        begin
            out_reg <= skid_vld_reg ? skid_reg : rad_data;
        end
        else if (offer)
        begin
            skid_reg <= rad_data;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.radius, out_reg.center_y, out_reg.center_x};
    assign m_tuser  = {out_reg.overflow, out_reg.degenerate};

endmodule

// File: rtl/tcc_front.sv
// Front end: edge vectors, d, squared lengths and the two center numerators.
// Six register stages; depends on tcc_pkg.
module tcc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [tcc_pkg::IN_FIELDS_W-1:0]       in_coords,
    output logic                                  out_valid,
    output tcc_pkg::front_out_t                   out_data
);

    localparam int CW     = tcc_pkg::COORD_WIDTH;
    localparam int DIFF_W = tcc_pkg::DIFF_W;
    localparam int PROD_W = tcc_pkg::PROD_W;
    localparam int NORM_W = tcc_pkg::NORM_W;
    localparam int DS_W   = tcc_pkg::DS_W;
    localparam int DV_W   = tcc_pkg::DV_W;
    localparam int NUM_W  = tcc_pkg::NUM_W;

    typedef struct packed {
        logic signed [DIFF_W-1:0] bx;
        logic signed [DIFF_W-1:0] by;
        logic signed [DIFF_W-1:0] cx;
        logic signed [DIFF_W-1:0] cy;
    } vec_t;

    logic signed [CW-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y;

    logic [5:0]           vld_reg;
    logic signed [CW-1:0] x0_reg [0:4];
    logic signed [CW-1:0] y0_reg [0:4];
    vec_t                 vec_reg [0:2];
    vec_t                 vec_next;

    logic signed [PROD_W-1:0] bxcy_reg, bycx_reg, sqbx_reg, sqby_reg, sqcx_reg, sqcy_reg;
    logic signed [PROD_W-1:0] bxcy_next, bycx_next, sqbx_next, sqby_next, sqcx_next, sqcy_next;
    logic signed [DS_W-1:0]   d_reg [0:2];
    logic signed [DS_W-1:0]   d_next;
    logic [NORM_W-1:0]        nb_reg, nc_reg, nb_next, nc_next;
    logic signed [NUM_W-1:0]  pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [NUM_W-1:0]  pa_next, pb_next, pc_next, pd_next;
    logic signed [NUM_W:0]    numx_reg, numy_reg, numx_next, numy_next;
    tcc_pkg::front_out_t      out_reg, out_next;

    assign p0_x = $signed(in_coords[0*CW +: CW]);
    assign p0_y = $signed(in_coords[1*CW +: CW]);
    assign p1_x = $signed(in_coords[2*CW +: CW]);
    assign p1_y = $signed(in_coords[3*CW +: CW]);
    assign p2_x = $signed(in_coords[4*CW +: CW]);
    assign p2_y = $signed(in_coords[5*CW +: CW]);

    // Advance valid bits with the stage enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // Stage 1: edge vectors from the first vertex
    always_comb
    begin
        vec_next.bx = DIFF_W'(p1_x) - DIFF_W'(p0_x);
        vec_next.by = DIFF_W'(p1_y) - DIFF_W'(p0_y);
        vec_next.cx = DIFF_W'(p2_x) - DIFF_W'(p0_x);
        vec_next.cy = DIFF_W'(p2_y) - DIFF_W'(p0_y);
    end

    // Stage 2: cross terms and squares
    always_comb
    begin
        bxcy_next = vec_reg[0].bx * vec_reg[0].cy;
        bycx_next = vec_reg[0].by * vec_reg[0].cx;
        sqbx_next = vec_reg[0].bx * vec_reg[0].bx;
        sqby_next = vec_reg[0].by * vec_reg[0].by;
        sqcx_next = vec_reg[0].cx * vec_reg[0].cx;
        sqcy_next = vec_reg[0].cy * vec_reg[0].cy;
    end

    // Stage 3: d and squared edge lengths
    always_comb
    begin
        d_next  = (DS_W'(bxcy_reg) - DS_W'(bycx_reg)) <<< 1;
        nb_next = NORM_W'(sqbx_reg) + NORM_W'(sqby_reg);
        nc_next = NORM_W'(sqcx_reg) + NORM_W'(sqcy_reg);
    end

    // Stage 4: numerator products
    always_comb
    begin
        pa_next = NUM_W'(vec_reg[2].cy) * $signed({1'b0, nb_reg});
        pb_next = NUM_W'(vec_reg[2].by) * $signed({1'b0, nc_reg});
        pc_next = NUM_W'(vec_reg[2].bx) * $signed({1'b0, nc_reg});
        pd_next = NUM_W'(vec_reg[2].cx) * $signed({1'b0, nb_reg});
    end

    // Stage 5: numerators
    always_comb
    begin
        numx_next = (NUM_W+1)'(pa_reg) - (NUM_W+1)'(pb_reg);
        numy_next = (NUM_W+1)'(pc_reg) - (NUM_W+1)'(pd_reg);
    end

    // Stage 6: split into magnitudes and quotient signs
    always_comb
    begin
        logic signed [NUM_W:0]  ax;
        logic signed [NUM_W:0]  ay;
        logic signed [DS_W-1:0] ad;
        ax = numx_reg[NUM_W] ? -numx_reg : numx_reg;
        ay = numy_reg[NUM_W] ? -numy_reg : numy_reg;
        ad = d_reg[2][DS_W-1] ? -d_reg[2] : d_reg[2];
        out_next.nx_mag     = ax[NUM_W-1:0];
        out_next.ny_mag     = ay[NUM_W-1:0];
        out_next.qx_neg     = numx_reg[NUM_W] ^ d_reg[2][DS_W-1];
        out_next.qy_neg     = numy_reg[NUM_W] ^ d_reg[2][DS_W-1];
        out_next.dv         = ad[DV_W-1:0];
        out_next.side.x0    = x0_reg[4];
        out_next.side.y0    = y0_reg[4];
        out_next.side.degen = (d_reg[2] == '0);
    end

    // Hold payload registers while the pipe is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg[0] <= p0_x;
            y0_reg[0] <= p0_y;
            for (int i = 1; i < 5; i++)
            begin
                x0_reg[i] <= x0_reg[i-1];
                y0_reg[i] <= y0_reg[i-1];
            end
            vec_reg[0] <= vec_next;
            vec_reg[1] <= vec_reg[0];
            vec_reg[2] <= vec_reg[1];
            bxcy_reg   <= bxcy_next;
            bycx_reg   <= bycx_next;
            sqbx_reg   <= sqbx_next;
            sqby_reg   <= sqby_next;
            sqcx_reg   <= sqcx_next;
            sqcy_reg   <= sqcy_next;
            d_reg[0]   <= d_next;
            d_reg[1]   <= d_reg[0];
            d_reg[2]   <= d_reg[1];
            nb_reg     <= nb_next;
            nc_reg     <= nc_next;
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            pc_reg     <= pc_next;
            pd_reg     <= pd_next;
            numx_reg   <= numx_next;
            numy_reg   <= numy_next;
            out_reg    <= out_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = out_reg;

endmodule

// File: rtl/tcc_div.sv
// Pipelined restoring divider: one quotient bit per stage for both center offsets.
// QUO_W register stages sharing one divisor; depends on tcc_pkg.
module tcc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  tcc_pkg::front_out_t  in_data,
    output logic                 out_valid,
    output tcc_pkg::div_out_t    out_data
);

    localparam int DV_W  = tcc_pkg::DV_W;
    localparam int QUO_W = tcc_pkg::QUO_W;

    typedef struct packed {
        logic [DV_W-1:0]     rem_x;
        logic [DV_W-1:0]     rem_y;
        logic [QUO_W-1:0]    nq_x;
        logic [QUO_W-1:0]    nq_y;
        logic [DV_W-1:0]     dv;
        logic                qx_neg;
        logic                qy_neg;
        tcc_pkg::div_side_t  side;
    } div_stage_t;

    // Shift one dividend bit into the remainder and one quotient bit into nq
    function automatic logic [DV_W+QUO_W-1:0] div_step(
        input logic [DV_W-1:0]  rem,
        input logic [QUO_W-1:0] nq,
        input logic [DV_W-1:0]  dv
    );
        logic [DV_W:0] trial;
        logic [DV_W:0] diff;
        logic          ge;
        trial = {rem, nq[QUO_W-1]};
        diff  = trial - {1'b0, dv};
        ge    = (trial >= {1'b0, dv});
        div_step = {(ge ? diff[DV_W-1:0] : trial[DV_W-1:0]), nq[QUO_W-2:0], ge};
    endfunction

    logic [QUO_W-1:0] vld_reg;
    div_stage_t       st_in;
    div_stage_t       st_reg [1:QUO_W];

    // Load the scaled dividend with an empty remainder
    always_comb
    begin
        st_in.rem_x  = '0;
        st_in.rem_y  = '0;
        st_in.nq_x   = QUO_W'(in_data.nx_mag) << tcc_pkg::FRAC_BITS;
        st_in.nq_y   = QUO_W'(in_data.ny_mag) << tcc_pkg::FRAC_BITS;
        st_in.dv     = in_data.dv;
        st_in.qx_neg = in_data.qx_neg;
        st_in.qy_neg = in_data.qy_neg;
        st_in.side   = in_data.side;
    end

    // Advance valid bits with the stage enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QUO_W-2:0], in_valid};
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_stage
        div_stage_t src;
        div_stage_t stage_next;

        if (k == 1)
        begin : g_first
            assign src = st_in;
        end
        else
        begin : g_rest
            assign src = st_reg[k-1];
        end

        // Resolve one quotient bit per lane
        always_comb
        begin
            stage_next = src;
            {stage_next.rem_x, stage_next.nq_x} = div_step(src.rem_x, src.nq_x, src.dv);
            {stage_next.rem_y, stage_next.nq_y} = div_step(src.rem_y, src.nq_y, src.dv);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= stage_next;
            end
        end
    end

    assign out_valid       = vld_reg[QUO_W-1];
    assign out_data.qx_mag = st_reg[QUO_W].nq_x;
    assign out_data.qy_mag = st_reg[QUO_W].nq_y;
    assign out_data.qx_neg = st_reg[QUO_W].qx_neg;
    assign out_data.qy_neg = st_reg[QUO_W].qy_neg;
    assign out_data.side   = st_reg[QUO_W].side;

endmodule

// File: rtl/tcc_rad.sv
// Back end: saturated center, squared offset length and a pipelined integer root.
// Three arithmetic stages then one stage per root bit; depends on tcc_pkg.
module tcc_rad (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  tcc_pkg::div_out_t  in_data,
    output logic               out_valid,
    output tcc_pkg::result_t   out_data
);

    localparam int CW    = tcc_pkg::COORD_WIDTH;
    localparam int QUO_W = tcc_pkg::QUO_W;
    localparam int RES_W = tcc_pkg::RES_W;
    localparam int SQS_W = tcc_pkg::SQS_W;
    localparam int REM_W = tcc_pkg::REM_W;
    localparam int CS_W  = QUO_W + CW + 2;
    localparam int DEPTH = RES_W + 3;

    typedef struct packed {
        logic [RES_W-1:0] center_x;
        logic [RES_W-1:0] center_y;
        logic             ovf_c;
        logic             big;
        logic             degen;
    } rad_side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [SQS_W-1:0] x;
        logic [RES_W-1:0] root;
        logic             sat;
        rad_side_t        side;
    } root_stage_t;

    // Clamp to the signed 32-bit range; top bit flags saturation
    function automatic logic [RES_W:0] sat32(input logic signed [CS_W-1:0] v);
        logic [CS_W-RES_W:0] hi;
        hi = v[CS_W-1:RES_W-1];
        if ((&hi) || !(|hi))
        begin
            sat32 = {1'b0, v[RES_W-1:0]};
        end
        else if (v[CS_W-1])
        begin
            sat32 = {1'b1, 1'b1, {(RES_W-1){1'b0}}};
        end
        else
        begin
            sat32 = {1'b1, 1'b0, {(RES_W-1){1'b1}}};
        end
    endfunction

    logic [DEPTH-1:0] vld_reg;
    rad_side_t        s1_side_reg, s1_side_next;
    logic [RES_W-1:0] ax_reg, ay_reg, ax_next, ay_next;
    rad_side_t        s2_side_reg;
    logic [SQS_W-1:0] sqx_reg, sqy_reg, sqx_next, sqy_next;
    root_stage_t      st_in_reg, st_in_next;
    root_stage_t      st_reg [1:RES_W];

    // Advance valid bits with the stage enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    // Stage 1: signed offsets, centers, clamp and range flags
    always_comb
    begin
        logic signed [QUO_W:0]  ux;
        logic signed [QUO_W:0]  uy;
        logic signed [CS_W-1:0] sx;
        logic signed [CS_W-1:0] sy;
        logic [RES_W:0]         cxs;
        logic [RES_W:0]         cys;
        ux  = in_data.qx_neg ? -$signed({1'b0, in_data.qx_mag}) : $signed({1'b0, in_data.qx_mag});
        uy  = in_data.qy_neg ? -$signed({1'b0, in_data.qy_mag}) : $signed({1'b0, in_data.qy_mag});
        sx  = (CS_W'(in_data.side.x0) <<< tcc_pkg::FRAC_BITS) + CS_W'(ux);
        sy  = (CS_W'(in_data.side.y0) <<< tcc_pkg::FRAC_BITS) + CS_W'(uy);
        cxs = sat32(sx);
        cys = sat32(sy);
        s1_side_next.center_x = cxs[RES_W-1:0];
        s1_side_next.center_y = cys[RES_W-1:0];
        s1_side_next.ovf_c    = cxs[RES_W] | cys[RES_W];
        s1_side_next.big      = ((in_data.qx_mag >> RES_W) != '0) ||
                                ((in_data.qy_mag >> RES_W) != '0);
        s1_side_next.degen    = in_data.side.degen;
        ax_next = RES_W'(in_data.qx_mag);
        ay_next = RES_W'(in_data.qy_mag);
    end

    // Stage 2: squares of the offsets
    always_comb
    begin
        sqx_next = {{RES_W{1'b0}}, ax_reg} * {{RES_W{1'b0}}, ax_reg};
        sqy_next = {{RES_W{1'b0}}, ay_reg} * {{RES_W{1'b0}}, ay_reg};
    end

    // Stage 3: radicand and radius saturation
    always_comb
    begin
        logic [SQS_W:0] s;
        s = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        st_in_next.rem  = '0;
        st_in_next.x    = s[SQS_W-1:0];
        st_in_next.root = '0;
        st_in_next.sat  = s[SQS_W] | s2_side_reg.big;
        st_in_next.side = s2_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
            s2_side_reg <= s1_side_reg;
            sqx_reg     <= sqx_next;
            sqy_reg     <= sqy_next;
            st_in_reg   <= st_in_next;
        end
    end

    for (genvar k = 1; k <= RES_W; k++)
    begin : g_root
        root_stage_t src;
        root_stage_t stage_next;

        if (k == 1)
        begin : g_first
            assign src = st_in_reg;
        end
        else
        begin : g_rest
            assign src = st_reg[k-1];
        end

        // Resolve one root bit from the next two radicand bits
        always_comb
        begin
            logic [REM_W+1:0] trial;
            logic [REM_W+1:0] sub;
            logic             ge;
            trial = {src.rem, src.x[SQS_W-1:SQS_W-2]};
            sub   = {2'b00, src.root, 2'b01};
            ge    = (trial >= sub);
            stage_next      = src;
            stage_next.rem  = ge ? REM_W'(trial - sub) : REM_W'(trial);
            stage_next.x    = src.x << 2;
            stage_next.root = {src.root[RES_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= stage_next;
            end
        end
    end

    // Assemble the result; collinear input zeroes every field but the degenerate flag
    always_comb
    begin
        if (st_reg[RES_W].side.degen)
        begin
            out_data            = '0;
            out_data.degenerate = 1'b1;
        end
        else
        begin
            out_data.center_x   = st_reg[RES_W].side.center_x;
            out_data.center_y   = st_reg[RES_W].side.center_y;
            out_data.radius     = st_reg[RES_W].sat ? '1 : st_reg[RES_W].root;
            out_data.degenerate = 1'b0;
            out_data.overflow   = st_reg[RES_W].side.ovf_c | st_reg[RES_W].sat;
        end
    end

    assign out_valid = vld_reg[DEPTH-1];

endmodule

// File: rtl/tcc_checker.sv
// Port-level checks on the circumcircle unit, attached by bind.
// Depends on tcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcc_port_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tcc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic [tcc_pkg::OUT_USER_W-1:0]     m_tuser
);

    logic                                               out_stall;
    logic                                               out_degen;
    logic                                               out_ovf;
    logic [tcc_pkg::OUT_USER_W+tcc_pkg::OUT_DATA_W-1:0] m_beat;

    assign out_stall = m_tvalid && !m_tready;
    assign out_degen = m_tvalid && m_tuser[tcc_pkg::USER_DEGEN];
    assign out_ovf   = m_tuser[tcc_pkg::USER_OVF];
    assign m_beat    = {m_tuser, m_tdata};

    // Hold a stalled output beat
    `TCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable(m_beat))

    // Collinear input leaves every other field at zero
    `TCC_ASSERT_NOW(a_degen_zero, clk, rst_n, out_degen, m_tdata == '0 && !out_ovf)

    // Input stalls only behind a waiting output beat
    `TCC_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_tready, m_tvalid)

    // Input stays open when the output was not stalled
    `TCC_ASSERT_NEXT(a_ready_keep, clk, rst_n, s_tready && !out_stall, s_tready)

endmodule

bind triangle_circumcircle_2d_unit tcc_port_checker u_tcc_checker (.*);
